### rtl/i64f32_pkg.sv
// shared types and constants for the int64/float32 converter
package i64f32_pkg;

    localparam logic [1:0] ACT_I2F = 2'd0;
    localparam logic [1:0] ACT_F2S = 2'd1;
    localparam logic [1:0] ACT_F2U = 2'd2;

    localparam int IN_W  = 104;
    localparam int OUT_W = 104;

    typedef struct packed {
        logic [1:0]  action;
        logic        neg;
        logic [63:0] mag;
        logic [31:0] fbits;
    } s1_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        neg;
        logic [5:0]  pos;
        logic        zero;
        logic [63:0] mag;
        logic [31:0] fbits;
        logic [63:0] fmag;
    } s2_t;

    typedef struct packed {
        logic [31:0] fres;
        logic [63:0] ires;
        logic        sat;
    } res_t;

endpackage

### rtl/i64f32_stage.sv
// one pipeline register stage with valid and stall
module i64f32_stage #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic         valid_reg;
    logic [W-1:0] data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end
endmodule

### rtl/int64_float32_converter_core.sv
// top level of the int64/float32 converter pipeline
// Fully pipelined converter: accepts one transfer per cycle while m_axis is not stalled
// and passes each result through sign and magnitude, leading-one search with float
// mantissa alignment, then round and saturate into the output register. Backpressure on
// m_axis stalls all stages without losing transfers.
module int64_float32_converter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // action[1:0], int_value[65:2], float_bits[97:66], zero pad
    input  logic [i64f32_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // float_result[31:0], int_result[95:32], saturated[96], pad
    output logic [i64f32_pkg::OUT_W-1:0]  m_axis_tdata
);
    logic [1:0]  in_act;
    logic [63:0] in_int;
    logic [31:0] in_fb;
    assign in_act = s_axis_tdata[1:0];
    assign in_int = s_axis_tdata[65:2];
    assign in_fb  = s_axis_tdata[97:66];

    // stage 1: sign and magnitude
    i64f32_pkg::s1_t s1_in, s1_out;
    logic s1_v, s1_r;
    always_comb begin
        s1_in.action = in_act;
        s1_in.neg    = in_int[63];
        s1_in.mag    = in_int[63] ? (64'd0 - in_int) : in_int;
        s1_in.fbits  = in_fb;
    end
    i64f32_stage #(.W($bits(i64f32_pkg::s1_t))) u_s1 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s1_in),
        .out_valid(s1_v), .out_ready(s1_r), .out_data(s1_out)
    );

    // stage 2: leading one position, float mantissa alignment
    i64f32_pkg::s2_t s2_in, s2_out;
    logic s2_v, s2_r;
    logic [7:0] s2_u;
    always_comb begin
        s2_in.action = s1_out.action;
        s2_in.neg    = s1_out.neg;
        s2_in.mag    = s1_out.mag;
        s2_in.fbits  = s1_out.fbits;
        s2_in.zero   = (s1_out.mag == 64'd0);
        s2_in.pos    = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (s1_out.mag[i]) begin
                s2_in.pos = 6'(i);
            end
        end
        s2_u = s1_out.fbits[30:23] - 8'd127;
        if (s2_u < 8'd23) begin
            s2_in.fmag = {40'd0, 1'b1, s1_out.fbits[22:0]} >> (5'd23 - s2_u[4:0]);
        end else begin
            s2_in.fmag = {40'd0, 1'b1, s1_out.fbits[22:0]} << (s2_u[5:0] - 6'd23);
        end
    end
    i64f32_stage #(.W($bits(i64f32_pkg::s2_t))) u_s2 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s1_v), .in_ready(s1_r), .in_data(s2_in),
        .out_valid(s2_v), .out_ready(s2_r), .out_data(s2_out)
    );

    // stage 3: normalize, round, float decode and saturate
    i64f32_pkg::res_t r_in, r_out;
    logic [63:0] norm;
    logic [24:0] keep;
    logic        rbit, sticky;
    logic [7:0]  fexp;
    logic [7:0]  e;
    logic [22:0] frac;
    logic        fneg;
    logic [7:0]  u;
    always_comb begin
        norm   = s2_out.mag << (6'd63 - s2_out.pos);
        rbit   = norm[39];
        sticky = |norm[38:0];
        keep   = {1'b0, norm[63:40]} + 25'(rbit && (sticky || norm[40]));
        fexp   = 8'd127 + {2'b00, s2_out.pos};
        if (keep[24]) begin
            fexp = fexp + 8'd1;
        end
        e    = s2_out.fbits[30:23];
        frac = s2_out.fbits[22:0];
        fneg = s2_out.fbits[31];
        u    = e - 8'd127;
        r_in = '0;
        case (s2_out.action)
            i64f32_pkg::ACT_I2F: begin
                if (!s2_out.zero) begin
                    r_in.fres = {s2_out.neg, fexp,
                                 keep[24] ? keep[23:1] : keep[22:0]};
                end
            end
            i64f32_pkg::ACT_F2S, i64f32_pkg::ACT_F2U: begin
                if (e == 8'hFF && frac != 23'd0) begin
                    r_in.sat  = 1'b1;
                    r_in.ires = (s2_out.action == i64f32_pkg::ACT_F2U) ? '1
                                : 64'h7FFF_FFFF_FFFF_FFFF;
                end else if (s2_out.action == i64f32_pkg::ACT_F2U) begin
                    if (fneg && (e != 8'd0 || frac != 23'd0)) begin
                        r_in.sat  = 1'b1;
                        r_in.ires = '1;
                    end else if (e < 8'd127) begin
                        r_in.ires = '0;
                    end else if (u >= 8'd64) begin
                        r_in.sat  = 1'b1;
                        r_in.ires = '1;
                    end else begin
                        r_in.ires = s2_out.fmag;
                    end
                end else begin
                    if (e < 8'd127) begin
                        r_in.ires = '0;
                    end else if (u >= 8'd63) begin
                        if (fneg) begin
                            r_in.ires = 64'h8000_0000_0000_0000;
                            r_in.sat  = !(u == 8'd63 && frac == 23'd0);
                        end else begin
                            r_in.ires = 64'h7FFF_FFFF_FFFF_FFFF;
                            r_in.sat  = 1'b1;
                        end
                    end else begin
                        r_in.ires = fneg ? (64'd0 - s2_out.fmag) : s2_out.fmag;
                    end
                end
            end
            default: r_in = '0;
        endcase
    end
    i64f32_stage #(.W($bits(i64f32_pkg::res_t))) u_s3 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s2_v), .in_ready(s2_r), .in_data(r_in),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(r_out)
    );

    assign m_axis_tdata = {7'd0, r_out.sat, r_out.ires, r_out.fres};
endmodule

### sim/tb_int64_float32_converter_core.sv
// testbench for the int64/float32 converter: directed table plus random operands, self-checked
module tb_int64_float32_converter_core;

    typedef struct {
        logic [1:0]  action;
        logic [63:0] ival;
        logic [31:0] fbits;
    } op_t;

    typedef struct {
        logic        known;
        logic [31:0] fres;
        logic [63:0] ires;
        logic        sat;
    } row_t;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int LIMIT = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;

    i64f32_pkg::res_t pending_results[$];
    int    errors = 0;
    int    cycles = 0;
    bit    quiet = 1'b0;

    int64_float32_converter_core DUT (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] to_float(logic [63:0] raw);
        logic        neg;
        logic [63:0] mag, keep, rem, half;
        int          p, sh;
        logic [7:0]  ex;
        neg = raw[63];
        mag = neg ? -raw : raw;
        if (mag == 0) return 32'h0;
        p = 0;
        for (int i = 0; i < 64; i++) if (mag[i]) p = i;
        ex = 8'(127 + p);
        if (p <= 23) begin
            keep = mag << (23 - p);
        end else begin
            sh = p - 23;
            rem = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            keep = mag >> sh;
            if (rem > half || (rem == half && keep[0])) keep++;
            if (keep == (64'd1 << 24)) begin
                keep >>= 1;
                ex++;
            end
        end
        return {neg, ex, keep[22:0]};
    endfunction

    function automatic void to_int(logic [31:0] b, bit uns, output logic [63:0] r,
                                   output logic s);
        logic [7:0]  e;
        logic [63:0] m, mag;
        int          u;
        e = b[30:23];
        m = {40'd0, 1'b1, b[22:0]};
        s = 1'b0;
        r = '0;
        if (e == 8'hFF && b[22:0] != 0) begin
            r = uns ? '1 : 64'h7FFF_FFFF_FFFF_FFFF;
            s = 1'b1;
        end else if (uns && b[31] && b[30:0] != 0) begin
            r = '1;
            s = 1'b1;
        end else if (e >= 127) begin
            u = int'(e) - 127;
            if (uns && u >= 64) begin
                r = '1;
                s = 1'b1;
            end else if (!uns && u >= 63) begin
                r = b[31] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                s = !(b[31] && u == 63 && b[22:0] == 0);
            end else begin
                mag = (u >= 23) ? m << (u - 23) : m >> (23 - u);
                r = (b[31] && !uns) ? -mag : mag;
            end
        end
    endfunction

    function automatic i64f32_pkg::res_t convert(op_t op);
        i64f32_pkg::res_t r;
        r = '0;
        case (op.action)
            i64f32_pkg::ACT_I2F: r.fres = to_float(op.ival);
            i64f32_pkg::ACT_F2S: to_int(op.fbits, 1'b0, r.ires, r.sat);
            i64f32_pkg::ACT_F2U: to_int(op.fbits, 1'b1, r.ires, r.sat);
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // result side: random stalls, checks each transfer
    initial begin
        i64f32_pkg::res_t want;
        int   n;
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet && $urandom_range(3) == 0) begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    report("unexpected transfer", m_axis_tdata[63:0], 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[31:0] !== want.fres)
                        report("float_result", m_axis_tdata[31:0], want.fres);
                    if (m_axis_tdata[95:32] !== want.ires)
                        report("int_result", m_axis_tdata[95:32], want.ires);
                    if (m_axis_tdata[96] !== want.sat)
                        report("saturated", m_axis_tdata[96], want.sat);
                end
            end
        end
    end

    task automatic send(op_t op, row_t row);
        i64f32_pkg::res_t r;
        int   n;
        r = convert(op);
        if (row.known && (r.fres !== row.fres || r.ires !== row.ires || r.sat !== row.sat))
            report("table row", {op.ival[31:0], op.fbits}, row.ires);
        if (!quiet && $urandom_range(3) == 0) begin
            s_axis_tvalid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, op.fbits, op.ival, op.action};
        pending_results.push_back(r);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(4))
            0: b[30:23] = 8'($urandom_range(100, 192));
            1: b[30:23] = 8'($urandom_range(120, 140));
            2: b[30:23] = 8'($urandom_range(185, 191));
            3: b[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return b;
    endfunction

    initial begin
        op_t  op;
        row_t rows[$];
        op_t  ops[$];
        int   k;
        // directed table: operation, expected where obvious
        ops = '{
            '{i64f32_pkg::ACT_I2F, 64'd0, 32'h0},
            '{i64f32_pkg::ACT_I2F, 64'd1, 32'h0},
            '{i64f32_pkg::ACT_I2F, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0},
            '{i64f32_pkg::ACT_I2F, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0},
            '{i64f32_pkg::ACT_I2F, 64'h8000_0000_0000_0000, 32'h0},
            '{i64f32_pkg::ACT_I2F, 64'd16777217, 32'h0},
            '{i64f32_pkg::ACT_I2F, 64'd16777219, 32'h0},
            '{i64f32_pkg::ACT_F2S, 64'd0, 32'h7FC0_0000},
            '{i64f32_pkg::ACT_F2S, 64'd0, 32'hFFC0_0001},
            '{i64f32_pkg::ACT_F2S, 64'd0, 32'h7F80_0000},
            '{i64f32_pkg::ACT_F2S, 64'd0, 32'hFF80_0000},
            '{i64f32_pkg::ACT_F2S, 64'd0, 32'hDF00_0000},
            '{i64f32_pkg::ACT_F2S, 64'd0, 32'hDF00_0001},
            '{i64f32_pkg::ACT_F2S, 64'd0, 32'h8000_0001},
            '{i64f32_pkg::ACT_F2S, 64'd0, 32'hBFC0_0000},
            '{i64f32_pkg::ACT_F2U, 64'd0, 32'h8000_0000},
            '{i64f32_pkg::ACT_F2U, 64'd0, 32'h8000_0001},
            '{i64f32_pkg::ACT_F2U, 64'd0, 32'h5F80_0000},
            '{i64f32_pkg::ACT_F2U, 64'd0, 32'h5F7F_FFFF},
            '{i64f32_pkg::ACT_F2U, 64'd0, 32'h7FFF_FFFF},
            '{i64f32_pkg::ACT_F2U, 64'd0, 32'h3F7F_FFFF},
            '{ACT_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF}
        };
        rows = '{
            '{1, 32'h0, 64'h0, 0}, '{1, 32'h3F80_0000, 64'h0, 0},
            '{1, 32'hBF80_0000, 64'h0, 0}, '{1, 32'h5F00_0000, 64'h0, 0},
            '{1, 32'hDF00_0000, 64'h0, 0}, '{1, 32'h4B80_0000, 64'h0, 0},
            '{1, 32'h4B80_0002, 64'h0, 0},
            '{1, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF, 1}, '{1, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF, 1},
            '{1, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF, 1}, '{1, 32'h0, 64'h8000_0000_0000_0000, 1},
            '{1, 32'h0, 64'h8000_0000_0000_0000, 0}, '{1, 32'h0, 64'h8000_0000_0000_0000, 1},
            '{1, 32'h0, 64'h0, 0}, '{0, 32'h0, 64'h0, 0},
            '{1, 32'h0, 64'h0, 0}, '{1, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1},
            '{1, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1}, '{1, 32'h0, 64'hFFFF_FF00_0000_0000, 0},
            '{1, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1}, '{1, 32'h0, 64'h0, 0},
            '{1, 32'h0, 64'h0, 0}
        };
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (ops[i]) send(ops[i], rows[i]);
        for (int i = 0; i < 1450; i++) begin
            if (i == 1250) quiet = 1'b1;
            k = $urandom_range(19);
            op.action = (k < 7) ? i64f32_pkg::ACT_I2F :
                        (k < 12) ? i64f32_pkg::ACT_F2S :
                        (k < 18) ? i64f32_pkg::ACT_F2U : ACT_NONE;
            op.ival = {$urandom, $urandom};
            if ($urandom_range(2) == 0) op.ival = $signed(op.ival) >>> $urandom_range(63);
            op.fbits = rand_float();
            send(op, '{0, 32'h0, 64'h0, 0});
        end
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/i64f32_pkg.sv
rtl/i64f32_stage.sv
rtl/int64_float32_converter_core.sv
sim/tb_int64_float32_converter_core.sv
